/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers for the message start finder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is held
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every rising edge, off while reset is held
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, off while reset is held
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

/* src/hmsf_pkg.sv */
// ----------------------------------------------------------------------------
// hmsf_pkg
// types, flag tables and match helpers for the message start finder
// ----------------------------------------------------------------------------
package hmsf_pkg;

  localparam int unsigned MAX_BUFFER = 65536;
  localparam int unsigned OFFSET_W   = 16;
  localparam int unsigned WIN        = 8;
  localparam int unsigned VIEW_LEN   = WIN + 1;
  localparam int unsigned LEN_W      = 4;

  // saturation point of the byte position
  localparam logic [OFFSET_W-1:0] POS_TOP =
    OFFSET_W'(((MAX_BUFFER - 1) > 65535) ? 65535 : (MAX_BUFFER - 1));

  localparam logic KIND_REQUEST  = 1'b0;
  localparam logic KIND_RESPONSE = 1'b1;

  // byte 0 is the newest byte
  typedef logic [VIEW_LEN-1:0][7:0] window_t;

  // text right aligned: the last character of the flag sits in byte 0
  typedef struct packed {
    window_t          text;
    logic [LEN_W-1:0] len;
  } flag_t;

  typedef struct packed {
    logic             term;
    logic             flag;
    logic [LEN_W-1:0] back;
  } match_t;

  localparam int unsigned NUM_REQ  = 9;
  localparam int unsigned NUM_RESP = 2;

  localparam flag_t TERM_FLAG = '{text: window_t'("\r\n\r\n"), len: LEN_W'(4)};

  localparam flag_t REQ_FLAGS [NUM_REQ] = '{
    '{text: window_t'("GET "),     len: LEN_W'(4)},
    '{text: window_t'("HEAD "),    len: LEN_W'(5)},
    '{text: window_t'("POST "),    len: LEN_W'(5)},
    '{text: window_t'("PUT "),     len: LEN_W'(4)},
    '{text: window_t'("DELETE "),  len: LEN_W'(7)},
    '{text: window_t'("CONNECT "), len: LEN_W'(8)},
    '{text: window_t'("OPTIONS "), len: LEN_W'(8)},
    '{text: window_t'("TRACE "),   len: LEN_W'(6)},
    '{text: window_t'("PATCH "),   len: LEN_W'(6)}
  };

  localparam flag_t RESP_FLAGS [NUM_RESP] = '{
    '{text: window_t'("HTTP/1.1 "), len: LEN_W'(9)},
    '{text: window_t'("HTTP/1.0 "), len: LEN_W'(9)}
  };

  // true when the flag ends on the newest byte of the view
  function automatic logic flag_hit(window_t view, flag_t f);
    logic hit;
    hit = (f.len != '0);
    for (int j = 0; j < VIEW_LEN; j++) begin
      if ((LEN_W'(j) < f.len) && (view[j] != f.text[j])) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

endpackage

/* src/hmsf_if.sv */
// ----------------------------------------------------------------------------
// hmsf channel interfaces
// valid/ready channels for bytes in, results out and the kind register
// ----------------------------------------------------------------------------
interface hmsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hmsf_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] start_offset;

  modport source (output valid, output found, output start_offset, input ready);
  modport sink   (input valid, input found, input start_offset, output ready);
endinterface

interface hmsf_cfg_if;
  logic valid;
  logic ready;
  logic message_kind;

  modport source (output valid, output message_kind, input ready);
  modport sink   (input valid, input message_kind, output ready);
endinterface

/* src/hmsf_match.sv */
// ----------------------------------------------------------------------------
// hmsf_match
// parallel compare of the byte window against terminator and start flags
// ----------------------------------------------------------------------------
module hmsf_match (
  input  hmsf_pkg::window_t window_i,
  input  logic              kind_i,
  output hmsf_pkg::match_t  match_o
);
  import hmsf_pkg::*;

  logic [LEN_W-1:0] best_len;
  logic             any_hit;

  // shortest matching flag gives the latest start
  always_comb begin
    best_len = '1;
    any_hit  = 1'b0;
    if (kind_i == KIND_RESPONSE) begin
      for (int k = 0; k < NUM_RESP; k++) begin
        if (flag_hit(window_i, RESP_FLAGS[k]) && (RESP_FLAGS[k].len < best_len)) begin
          best_len = RESP_FLAGS[k].len;
          any_hit  = 1'b1;
        end
      end
    end else begin
      for (int k = 0; k < NUM_REQ; k++) begin
        if (flag_hit(window_i, REQ_FLAGS[k]) && (REQ_FLAGS[k].len < best_len)) begin
          best_len = REQ_FLAGS[k].len;
          any_hit  = 1'b1;
        end
      end
    end
    match_o.term = flag_hit(window_i, TERM_FLAG);
    match_o.flag = any_hit;
    match_o.back = best_len - LEN_W'(1);
  end

endmodule

/* src/http_message_start_finder.sv */
// ----------------------------------------------------------------------------
// http_message_start_finder
// finds the offset where an http message start line begins in a byte buffer
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one buffer byte per transaction, last_byte marks the final
//   byte. cfg_ch writes message_kind (0 request methods, 1 response versions)
//   and is always ready; write it only while the block is idle.
//   out_ch carries at most one result per buffer: found with the latest flag
//   start of the first segment that holds a flag, closed by crlfcrlf, or
//   found = 0 and offset 0 at the end of a buffer with no report.
// timing:
//   a byte accepted on in_ch is held in the input register and evaluated
//   from there into the result register, which drives out_ch until the
//   result is taken. one byte per cycle is sustained while out_ch does not
//   stall; the single loop is the window compare plus the offset subtract
//   and compare.
// stall:
//   when out_ch stalls with a result pending, the input register keeps one
//   more byte and in_ch.ready drops until the result is taken.
// reset:
//   rst_ni clears the window, position, best offset, pending result and
//   message_kind (request flags selected).
// ----------------------------------------------------------------------------
module http_message_start_finder (
  input  logic       clk_i,
  input  logic       rst_ni,
  hmsf_in_if.sink    in_ch,
  hmsf_cfg_if.sink   cfg_ch,
  hmsf_out_if.source out_ch
);
  import hmsf_pkg::*;
  `include "assert_macros.svh"

  // input register
  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             in_last_q;

  // per-buffer state and message kind
  logic [WIN-1:0][7:0]   recent_q, recent_d;
  logic [OFFSET_W-1:0]   pos_q, pos_d;
  logic [OFFSET_W-1:0]   best_start_q, best_start_d;
  logic                  best_valid_q, best_valid_d;
  logic                  reported_q, reported_d;
  logic                  kind_q;

  // result register
  logic                  out_valid_q, out_valid_d;
  logic                  out_found_q, out_found_d;
  logic [OFFSET_W-1:0]   out_offset_q, out_offset_d;

  logic                  adv;
  logic                  in_take;
  window_t               view;
  match_t                hit;
  logic [OFFSET_W-1:0]   flag_start;

  // an item moves on when the result slot is free or being emptied
  assign adv     = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;

  assign in_ch.ready  = !in_valid_q || adv;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_valid_q;
  assign out_ch.found        = out_found_q;
  assign out_ch.start_offset = out_offset_q;

  assign view = {recent_q, in_byte_q};

  hmsf_match u_match (
    .window_i (view),
    .kind_i   (kind_q),
    .match_o  (hit)
  );

  // start of the flag, clipped at offset zero
  assign flag_start = (pos_q >= OFFSET_W'(hit.back)) ? (pos_q - OFFSET_W'(hit.back)) : '0;

  always_comb begin
    recent_d     = recent_q;
    pos_d        = pos_q;
    best_start_d = best_start_q;
    best_valid_d = best_valid_q;
    reported_d   = reported_q;
    out_valid_d  = out_valid_q;
    out_found_d  = out_found_q;
    out_offset_d = out_offset_q;

    if (adv) begin
      out_valid_d = 1'b0;
      if (!reported_q) begin
        if (hit.term) begin
          // segment closes here
          if (best_valid_q) begin
            out_valid_d  = 1'b1;
            out_found_d  = 1'b1;
            out_offset_d = best_start_q;
            reported_d   = 1'b1;
          end
          best_valid_d = 1'b0;
          recent_d     = '0;
        end else begin
          if (hit.flag) begin
            if (!best_valid_q || (flag_start > best_start_q)) begin
              best_start_d = flag_start;
            end
            best_valid_d = 1'b1;
          end
          recent_d = {recent_q[WIN-2:0], in_byte_q};
        end
      end

      if (in_last_q) begin
        // end of buffer: not-found unless something was reported
        if (!out_valid_d && !reported_q) begin
          out_valid_d  = 1'b1;
          out_found_d  = 1'b0;
          out_offset_d = '0;
        end
        recent_d     = '0;
        pos_d        = '0;
        best_start_d = '0;
        best_valid_d = 1'b0;
        reported_d   = 1'b0;
      end else if (pos_q < POS_TOP) begin
        pos_d = pos_q + OFFSET_W'(1);
      end
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      recent_q     <= '0;
      pos_q        <= '0;
      best_start_q <= '0;
      best_valid_q <= 1'b0;
      reported_q   <= 1'b0;
      kind_q       <= KIND_REQUEST;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_q <= in_ch.valid;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        kind_q <= cfg_ch.message_kind;
      end
      recent_q     <= recent_d;
      pos_q        <= pos_d;
      best_start_q <= best_start_d;
      best_valid_q <= best_valid_d;
      reported_q   <= reported_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_ch.data_byte;
      in_last_q <= in_ch.last_byte;
    end
    out_found_q  <= out_found_d;
    out_offset_q <= out_offset_d;
  end

  `ASSERT_CLK(a_pos_sat, clk_i, rst_ni, pos_q <= POS_TOP,
    "byte position beyond saturation point")
  `ASSERT_IMPL(a_notfound_zero, clk_i, rst_ni, out_valid_q && !out_found_q,
    out_offset_q == '0, "not-found result with nonzero offset")
  `ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_valid_q && !in_ch.ready,
    out_valid_q && !out_ch.ready, "input stalled without a blocked result")
  `ASSERT_NEXT(a_report, clk_i, rst_ni, adv && hit.term && best_valid_q && !reported_q,
    out_valid_q && out_found_q, "terminator after a flag gave no found result")
  `ASSERT_NEXT(a_buf_clear, clk_i, rst_ni, adv && in_last_q,
    pos_q == '0 && !best_valid_q && !reported_q, "buffer state not cleared after last byte")

endmodule
